// File: hdl/gcac_pkg.sv
// Shared types and constants for the glyph cell alpha compositor.
// No dependencies; every other file in hdl/ imports this package.
package gcac_pkg;

  localparam int unsigned DEF_MAX_CELL_WIDTH  = 32;
  localparam int unsigned DEF_MAX_CELL_HEIGHT = 64;

  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COV_W      = 8;
  localparam int unsigned GW_W       = 6;
  localparam int unsigned CWREG_W    = 6;
  localparam int unsigned CHREG_W    = 7;
  localparam int unsigned COL_W      = 6;   // column counter
  localparam int unsigned ROW_W      = 7;   // row counter
  localparam int unsigned CW_W       = 7;   // effective width, holds up to 127
  localparam int unsigned CH_W       = 8;   // effective height, holds up to 255
  localparam int unsigned OCOL_W     = 5;
  localparam int unsigned OROW_W     = 6;
  localparam int unsigned ARGB_W     = 32;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [COLOR_W-1:0] FG_RESET     = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET     = 24'h000000;
  localparam logic [CWREG_W-1:0] CW_RESET     = 6'd8;
  localparam logic [CHREG_W-1:0] CH_RESET     = 7'd16;

  typedef enum logic [IDX_W-1:0] {
    CFG_FG_COLOR    = 2'd0,
    CFG_BG_COLOR    = 2'd1,
    CFG_CELL_WIDTH  = 2'd2,
    CFG_CELL_HEIGHT = 2'd3
  } cfg_idx_e;

  // Geometry and control handed from the register block to the sequencer.
  typedef struct packed {
    logic [CW_W-1:0] width;   // clamped cell width
    logic [CH_W-1:0] height;  // clamped cell height
    logic            clear;   // geometry written: restart the cell
  } geom_t;

endpackage

// File: hdl/gcac_cfg.sv
// Configuration registers and clamped cell geometry.
// Depends on gcac_pkg.
module gcac_cfg import gcac_pkg::*; #(
  parameter int unsigned MAX_CELL_WIDTH  = DEF_MAX_CELL_WIDTH,
  parameter int unsigned MAX_CELL_HEIGHT = DEF_MAX_CELL_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [COLOR_W-1:0] cfg_data_i,
  output logic [COLOR_W-1:0] fg_color_o,
  output logic [COLOR_W-1:0] bg_color_o,
  output geom_t              geom_o
);

  localparam logic [CW_W-1:0] MaxW = CW_W'(MAX_CELL_WIDTH);
  localparam logic [CH_W-1:0] MaxH = CH_W'(MAX_CELL_HEIGHT);

  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [CWREG_W-1:0] cw_q;
  logic [CHREG_W-1:0] ch_q;
  logic               wr;
  logic [CW_W-1:0]    cw_ext;
  logic [CH_W-1:0]    ch_ext;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
      cw_q <= CW_RESET;
      ch_q <= CH_RESET;
    end else if (wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FG_COLOR:    fg_q <= cfg_data_i;
        CFG_BG_COLOR:    bg_q <= cfg_data_i;
        CFG_CELL_WIDTH:  cw_q <= cfg_data_i[CWREG_W-1:0];
        CFG_CELL_HEIGHT: ch_q <= cfg_data_i[CHREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cw_ext = CW_W'(cw_q);
  assign ch_ext = CH_W'(ch_q);

  always_comb begin
    if (cw_q == '0)          geom_o.width = CW_W'(1);
    else if (cw_ext > MaxW)  geom_o.width = MaxW;
    else                     geom_o.width = cw_ext;
    if (ch_q == '0)          geom_o.height = CH_W'(1);
    else if (ch_ext > MaxH)  geom_o.height = MaxH;
    else                     geom_o.height = ch_ext;
    geom_o.clear = wr && ((cfg_index_i == CFG_CELL_WIDTH) ||
                          (cfg_index_i == CFG_CELL_HEIGHT));
  end

  assign fg_color_o = fg_q;
  assign bg_color_o = bg_q;

endmodule

// File: hdl/gcac_blend.sv
// Per-channel alpha blend of foreground over background, RGB888.
// Depends on gcac_pkg.
module gcac_blend import gcac_pkg::*; (
  input  logic [COLOR_W-1:0] fg_i,
  input  logic [COLOR_W-1:0] bg_i,
  input  logic [COV_W-1:0]   alpha_i,
  output logic [COLOR_W-1:0] rgb_o
);

  localparam int unsigned NCH = COLOR_W / CHAN_W;
  localparam int unsigned MW  = 2 * CHAN_W;

  logic [COV_W-1:0] inv_alpha;
  assign inv_alpha = ALPHA_OPAQUE - alpha_i;

  for (genvar c = 0; c < NCH; c++) begin : g_chan
    logic [MW-1:0] mix;
    logic [MW:0]   fold;
    // Floor of mix/255: exact for mix below 65535 (max here is 255*255).
    assign mix  = MW'(fg_i[c*CHAN_W +: CHAN_W]) * MW'(alpha_i)
                + MW'(bg_i[c*CHAN_W +: CHAN_W]) * MW'(inv_alpha);
    assign fold = (MW+1)'(mix) + (MW+1)'(1) + (MW+1)'(mix[MW-1:CHAN_W]);
    assign rgb_o[c*CHAN_W +: CHAN_W] = fold[MW-1:CHAN_W];
  end

endmodule

// File: hdl/gcac_seq.sv
// Input word register, cell position counters, row padding and output register.
// Depends on gcac_pkg; the blended color arrives from gcac_blend.
module gcac_seq import gcac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  geom_t              geom_i,
  input  logic [COLOR_W-1:0] bg_color_i,
  // input side
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_req_i,
  input  logic [COV_W-1:0]   in_cov_i,
  input  logic [GW_W-1:0]    in_gw_i,
  // blend unit
  output logic [COV_W-1:0]   blend_alpha_o,
  input  logic [COLOR_W-1:0] blend_rgb_i,
  // output side
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COLOR_W-1:0] out_rgb_o,
  output logic [OCOL_W-1:0]  out_col_o,
  output logic [OROW_W-1:0]  out_row_o,
  output logic               out_rend_o,
  output logic               out_cend_o
);

  logic               item_vld_q;
  logic               item_req_q;
  logic [COV_W-1:0]   item_cov_q;
  logic [GW_W-1:0]    item_gw_q;
  logic               pad_q, pad_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               out_vld_q;
  logic [COLOR_W-1:0] out_rgb_q;
  logic [OCOL_W-1:0]  out_col_q;
  logic [OROW_W-1:0]  out_row_q;
  logic               out_rend_q, out_cend_q;

  logic               out_free, emit, item_take, is_cov, rend, cend;
  logic [CW_W-1:0]    gw_ext, gw_sat, col_inc;
  logic [CH_W-1:0]    row_inc;
  logic [COL_W-1:0]   col_e;
  logic [ROW_W-1:0]   row_e;
  logic [COLOR_W-1:0] pix;

  assign out_free  = !out_vld_q || out_ready_i;
  assign item_take = out_free && !pad_q && item_vld_q;
  assign emit      = out_free && (pad_q || item_vld_q);
  assign in_ready_o = !item_vld_q || item_take;

  assign gw_ext = CW_W'(item_gw_q);
  assign gw_sat = (gw_ext > geom_i.width) ? geom_i.width : gw_ext;
  assign is_cov = !item_req_q && (gw_sat != '0);

  // Fold a stale position back into the cell.
  assign col_e   = (CW_W'(col_q) >= geom_i.width) ? '0 : col_q;
  assign row_e   = (CH_W'(row_q) >= geom_i.height) ? '0 : row_q;
  assign col_inc = CW_W'(col_e) + CW_W'(1);
  assign row_inc = CH_W'(row_e) + CH_W'(1);
  assign rend    = col_inc >= geom_i.width;
  assign cend    = rend && (row_inc >= geom_i.height);

  assign blend_alpha_o = item_cov_q;
  assign pix = (!pad_q && is_cov) ? blend_rgb_i : bg_color_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pad_d = pad_q;
    if (geom_i.clear) begin
      col_d = '0;
      row_d = '0;
      pad_d = 1'b0;
    end else if (emit) begin
      if (rend) begin
        col_d = '0;
        row_d = cend ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
      if (pad_q || !is_cov) pad_d = !rend;
      else                  pad_d = !rend && (col_inc >= gw_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      pad_q      <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      out_vld_q  <= 1'b0;
      out_rend_q <= 1'b0;
      out_cend_q <= 1'b0;
    end else begin
      pad_q <= pad_d;
      col_q <= col_d;
      row_q <= row_d;
      if (in_valid_i && in_ready_o) item_vld_q <= 1'b1;
      else if (item_take)           item_vld_q <= 1'b0;
      if (emit) begin
        out_vld_q  <= 1'b1;
        out_rend_q <= rend;
        out_cend_q <= cend;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_req_q <= in_req_i;
      item_cov_q <= in_cov_i;
      item_gw_q  <= in_gw_i;
    end
    if (emit) begin
      out_rgb_q <= pix;
      out_col_q <= col_e[OCOL_W-1:0];
      out_row_q <= row_e[OROW_W-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rgb_o   = out_rgb_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign out_rend_o  = out_rend_q;
  assign out_cend_o  = out_cend_q;

`ifndef SYNTHESIS
  a_cend_has_rend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_cend_q |-> out_rend_q)
    else $error("cell end without row end");
  a_pad_after_open_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q |-> !out_rend_q)
    else $error("padding active after a row end");
  a_no_take_while_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q |-> !item_take)
    else $error("item consumed during padding");
  a_stall_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i && !geom_i.clear |=> $stable(col_q) && $stable(row_q))
    else $error("position moved while output stalled");
`endif

endmodule

// File: hdl/glyph_cell_alpha_compositor_top.sv
// Top level of the glyph cell alpha compositor.
// Depends on gcac_pkg, gcac_cfg, gcac_blend and gcac_seq.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+------------------------------------------
//  s_axis  | in  | s_axis_tvalid_i/tready_o   | tdata coverage, glyph_width; tuser req_type
//  m_axis  | out | m_axis_tvalid_o/tready_i   | tdata argb, column, row; tlast row_end;
//          |     |                            | tuser cell_end
//  cfg     | in  | cfg_valid_i/cfg_ready_o    | cfg_index_i register, cfg_data_i value
//
// A coverage word gives one pixel, which is registered into the output register as the word
// moves out of the input register. A word that closes a row early, or an empty-row word,
// also gives one background pixel for each position that pads the row; the input stalls
// while padding runs. Reset clears counters and valid flags and sets the configuration
// registers to their reset values, with no clearing pass; payload registers are not reset.
// A stalled output holds its word and, unless the geometry is written, the cell position.
module glyph_cell_alpha_compositor_top import gcac_pkg::*; #(
  parameter int unsigned MAX_CELL_WIDTH  = DEF_MAX_CELL_WIDTH,
  parameter int unsigned MAX_CELL_HEIGHT = DEF_MAX_CELL_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // coverage stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [7:0] coverage, [13:8] glyph_width, [15:14] unused
  input  logic                   s_axis_tuser_i,  // [0] req_type
  // pixel stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // [31:0] pixel_argb, [36:32] pixel_column,
                                                  // [42:37] pixel_row, zeros above
  output logic                   m_axis_tlast_o,  // row_end
  output logic                   m_axis_tuser_o,  // [0] cell_end
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IDX_W-1:0]       cfg_index_i,
  input  logic [COLOR_W-1:0]     cfg_data_i
);

  localparam int unsigned OUT_USED = ARGB_W + OCOL_W + OROW_W;

  logic [COLOR_W-1:0] fg_color, bg_color, blend_rgb, out_rgb;
  logic [COV_W-1:0]   blend_alpha;
  logic [OCOL_W-1:0]  out_col;
  logic [OROW_W-1:0]  out_row;
  geom_t              geom;

  gcac_cfg #(
    .MAX_CELL_WIDTH (MAX_CELL_WIDTH),
    .MAX_CELL_HEIGHT(MAX_CELL_HEIGHT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fg_color_o (fg_color),
    .bg_color_o (bg_color),
    .geom_o     (geom)
  );

  // Blend sits between the input word register and the output register.
  gcac_blend u_blend (
    .fg_i   (fg_color),
    .bg_i   (bg_color),
    .alpha_i(blend_alpha),
    .rgb_o  (blend_rgb)
  );

  gcac_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .bg_color_i   (bg_color),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_req_i     (s_axis_tuser_i),
    .in_cov_i     (s_axis_tdata_i[COV_W-1:0]),
    .in_gw_i      (s_axis_tdata_i[COV_W +: GW_W]),
    .blend_alpha_o(blend_alpha),
    .blend_rgb_i  (blend_rgb),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_rgb_o    (out_rgb),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .out_rend_o   (m_axis_tlast_o),
    .out_cend_o   (m_axis_tuser_o)
  );

  // Pack the pixel word: opaque alpha on top of the pixel color (blended or background).
  assign m_axis_tdata_o = {{(OUT_TDATA_W-OUT_USED){1'b0}}, out_row, out_col,
                           ALPHA_OPAQUE, out_rgb};

endmodule
